>>> design/lmfp_pkg.sv
// Shared types and constants for the LIN master frame poll engine.
package lmfp_pkg;

  // Largest number of response data bytes before the checksum byte.
  localparam int unsigned MAX_DATA_BYTES = 8;
  // Smallest number of response data bytes before the checksum byte.
  localparam int unsigned MIN_DATA_BYTES = 3;

  // Fixed header and field widths.
  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RSP_LEN  = 1'b1;

  // Request codes on the input channel.
  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_BYTE    = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BREAK   = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_OUTCOME = 2'd2
  } kind_t;

  // Frame outcome codes.
  localparam logic [1:0] OC_OK       = 2'd0;
  localparam logic [1:0] OC_TIMEOUT  = 2'd1;
  localparam logic [1:0] OC_CSUM_ERR = 2'd2;

  // Position within the three-transaction header sequence.
  localparam logic [1:0] POS_BREAK = 2'd0;
  localparam logic [1:0] POS_SYNC  = 2'd1;
  localparam logic [1:0] POS_PID   = 2'd2;

  // Result set that one input produces, handed to the result sequencer.
  typedef struct packed {
    logic       hdr;      // 1: break, sync and identifier; 0: one outcome
    logic [7:0] pid;
    logic [1:0] outcome;
    logic [3:0] rain;
    logic [7:0] light;
    logic [7:0] status;
    logic [7:0] sum;
  } res_t;

  // Protected identifier: frame id with the two LIN 2.x parity bits.
  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Eight-bit add with end-around carry.
  function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

>>> design/lin_master_frame_poll.sv
// Top level of the LIN master frame poll engine.
// A start request (in_req_type 0) yields three result transactions: a break
// marker, the sync byte 0x55 and the protected identifier; response bytes
// (type 1) feed the enhanced checksum, and the byte after the configured number
// of data bytes (clamped to 3..8) yields one outcome transaction, as does a
// timeout (type 2) during a frame.
// The block accepts one input transaction per cycle: each is handled in a
// single pass between the input register and a one-set result buffer, and the
// first result is presented from the result buffer register. The result buffer
// holds one input's results; a start occupies it for three output transactions,
// during which inputs that give no result keep flowing and an input that gives
// a result waits. Configuration writes are always taken, as cfg_ready is tied high.
module lin_master_frame_poll (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_req_type,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_last,
  output logic [1:0]                      out_outcome,
  output logic [3:0]                      out_rain_level,
  output logic [7:0]                      out_light_level,
  output logic [7:0]                      out_sensor_state,
  output logic [7:0]                      out_expected_sum,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lmfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmfp_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import lmfp_pkg::*;

  logic res_free;
  logic res_load;
  res_t res_data;

  assign cfg_ready = 1'b1;

  // Frame state and checksum.
  lmfp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_rx_byte  (in_rx_byte),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .res_free    (res_free),
    .res_load    (res_load),
    .res_data    (res_data)
  );

  // Result delivery.
  lmfp_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_load         (res_load),
    .res_data         (res_data),
    .res_free         (res_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_tx_byte      (out_tx_byte),
    .out_last         (out_last),
    .out_outcome      (out_outcome),
    .out_rain_level   (out_rain_level),
    .out_light_level  (out_light_level),
    .out_sensor_state (out_sensor_state),
    .out_expected_sum (out_expected_sum)
  );

endmodule

>>> design/lmfp_core.sv
// Input register, configuration registers and frame state of the LIN poll engine.
module lmfp_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_req_type,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            cfg_valid,
  input  logic [lmfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmfp_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                            res_free,
  output logic                            res_load,
  output lmfp_pkg::res_t                  res_data
);
  import lmfp_pkg::*;

  // Input register.
  logic       in_vld_r;
  req_t       req_r;
  logic [7:0] byte_r;

  // Configuration registers.
  logic [5:0] frame_id_r;
  logic [3:0] rsp_len_r;

  // Frame state.
  logic       receiving_r, receiving_nxt;
  logic [3:0] byte_idx_r, byte_idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] pid_r, pid_nxt;
  logic [3:0] rain_r, rain_nxt;
  logic [7:0] light_r, light_nxt;
  logic [7:0] status_r, status_nxt;

  logic [3:0] eff_len;
  logic [7:0] new_pid;
  logic [7:0] exp_sum;
  logic       has_res;
  logic       fire;

  // Data length clamped to the supported range, read live on each byte.
  always_comb begin
    if (rsp_len_r < 4'(MIN_DATA_BYTES)) begin
      eff_len = 4'(MIN_DATA_BYTES);
    end else if (rsp_len_r > 4'(MAX_DATA_BYTES)) begin
      eff_len = 4'(MAX_DATA_BYTES);
    end else begin
      eff_len = rsp_len_r;
    end
  end

  assign new_pid = make_pid(frame_id_r);
  assign exp_sum = ~sum_r;

  // Does the held input produce any result transaction?
  always_comb begin
    unique case (req_r)
      REQ_START:   has_res = 1'b1;
      REQ_TIMEOUT: has_res = receiving_r;
      REQ_BYTE:    has_res = receiving_r && (byte_idx_r >= eff_len);
      default:     has_res = 1'b0;
    endcase
  end

  assign fire     = in_vld_r && (!has_res || res_free);
  assign res_load = fire && has_res;
  assign in_ready = !in_vld_r || fire;

  // Next frame state and the result set for the held input.
  always_comb begin
    receiving_nxt = receiving_r;
    byte_idx_nxt  = byte_idx_r;
    sum_nxt       = sum_r;
    pid_nxt       = pid_r;
    rain_nxt      = rain_r;
    light_nxt     = light_r;
    status_nxt    = status_r;
    res_data      = '0;
    unique case (req_r)
      REQ_START: begin
        pid_nxt       = new_pid;
        sum_nxt       = new_pid;
        byte_idx_nxt  = '0;
        rain_nxt      = '0;
        light_nxt     = '0;
        status_nxt    = '0;
        receiving_nxt = 1'b1;
        res_data.hdr  = 1'b1;
        res_data.pid  = new_pid;
      end
      REQ_TIMEOUT: begin
        if (receiving_r) begin
          receiving_nxt    = 1'b0;
          byte_idx_nxt     = '0;
          res_data.outcome = OC_TIMEOUT;
        end
      end
      REQ_BYTE: begin
        if (receiving_r) begin
          if (byte_idx_r < eff_len) begin
            if (byte_idx_r == 4'd0) begin
              rain_nxt = byte_r[3:0];
            end
            if (byte_idx_r == 4'd1) begin
              light_nxt = byte_r;
            end
            if (byte_idx_r == 4'd2) begin
              status_nxt = byte_r;
            end
            sum_nxt      = add_carry(sum_r, byte_r);
            byte_idx_nxt = byte_idx_r + 4'd1;
          end else begin
            receiving_nxt    = 1'b0;
            byte_idx_nxt     = '0;
            res_data.outcome = (byte_r == exp_sum) ? OC_OK : OC_CSUM_ERR;
            res_data.rain    = rain_r;
            res_data.light   = light_r;
            res_data.status  = status_r;
            res_data.sum     = exp_sum;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  // Input payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r  <= req_t'(in_req_type);
      byte_r <= in_rx_byte;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_id_r <= '0;
      rsp_len_r  <= 4'(MAX_DATA_BYTES);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_ID: frame_id_r <= cfg_data[5:0];
        CFG_RSP_LEN:  rsp_len_r  <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Frame state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      byte_idx_r  <= '0;
      sum_r       <= '0;
      pid_r       <= '0;
      rain_r      <= '0;
      light_r     <= '0;
      status_r    <= '0;
    end else if (fire) begin
      receiving_r <= receiving_nxt;
      byte_idx_r  <= byte_idx_nxt;
      sum_r       <= sum_nxt;
      pid_r       <= pid_nxt;
      rain_r      <= rain_nxt;
      light_r     <= light_nxt;
      status_r    <= status_nxt;
    end
  end

  // The running sum always starts from the protected identifier.
  a_seed: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req_r == REQ_START |=> sum_r == pid_r && byte_idx_r == 4'd0)
    else $error("running sum not seeded with protected identifier");

  // The byte counter never runs past the maximum data length.
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= 4'(MAX_DATA_BYTES))
    else $error("byte index beyond maximum data length");

  // An idle frame never produces a result from a byte or a timeout.
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && !receiving_r |-> req_r == REQ_START)
    else $error("result produced while idle");

endmodule

>>> design/lmfp_out.sv
// Result sequencer: holds one result set and emits it one transaction at a time.
module lmfp_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_load,
  input  lmfp_pkg::res_t res_data,
  output logic           res_free,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_tx_byte,
  output logic           out_last,
  output logic [1:0]     out_outcome,
  output logic [3:0]     out_rain_level,
  output logic [7:0]     out_light_level,
  output logic [7:0]     out_sensor_state,
  output logic [7:0]     out_expected_sum
);
  import lmfp_pkg::*;

  logic       ob_vld_r;
  logic [1:0] ob_pos_r;
  res_t       ob_res_r;
  logic       ob_last;

  assign ob_last  = !ob_res_r.hdr || (ob_pos_r == POS_PID);
  assign res_free = !ob_vld_r || (out_ready && ob_last);

  // Result fields from the held set and the sequence position.
  always_comb begin
    out_valid        = ob_vld_r;
    out_last         = ob_last;
    out_outcome      = '0;
    out_rain_level   = '0;
    out_light_level  = '0;
    out_sensor_state = '0;
    out_expected_sum = '0;
    out_tx_byte      = '0;
    if (ob_res_r.hdr) begin
      unique case (ob_pos_r)
        POS_BREAK: out_kind = KIND_BREAK;
        default:   out_kind = KIND_HEADER;
      endcase
      if (ob_pos_r == POS_SYNC) begin
        out_tx_byte = SYNC_BYTE;
      end else if (ob_pos_r == POS_PID) begin
        out_tx_byte = ob_res_r.pid;
      end
    end else begin
      out_kind         = KIND_OUTCOME;
      out_outcome      = ob_res_r.outcome;
      out_rain_level   = ob_res_r.rain;
      out_light_level  = ob_res_r.light;
      out_sensor_state = ob_res_r.status;
      out_expected_sum = ob_res_r.sum;
    end
  end

  // Buffer control: load a new set when free, otherwise step through the set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_vld_r <= 1'b0;
      ob_pos_r <= POS_BREAK;
    end else if (res_load) begin
      ob_vld_r <= 1'b1;
      ob_pos_r <= POS_BREAK;
    end else if (ob_vld_r && out_ready) begin
      if (ob_last) begin
        ob_vld_r <= 1'b0;
      end else begin
        ob_pos_r <= ob_pos_r + 2'd1;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      ob_res_r <= res_data;
    end
  end

  // An outcome set is a single transaction.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    ob_vld_r && !ob_res_r.hdr |-> ob_pos_r == POS_BREAK)
    else $error("outcome set left its first position");

  // A header sequence moves forward one step per accepted transaction.
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    ob_vld_r && ob_res_r.hdr && out_ready && ob_pos_r != POS_PID && !res_load
    |=> ob_vld_r && ob_pos_r == $past(ob_pos_r) + 2'd1)
    else $error("header sequence skipped or stalled");

  // A new set only replaces one that is fully delivered.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !ob_vld_r || (out_ready && ob_last))
    else $error("result set overwritten before delivery");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the LIN master frame poll engine.
`timescale 1ns / 1ps

module tb_top;
  import lmfp_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned DRAIN_LIMIT   = 3000;
  localparam int unsigned RANDOM_ITEMS  = 190;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned DIR_ROWS      = 28;

  // One result transaction as seen on the output channel.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [1:0] outcome;
    logic [3:0] rain;
    logic [7:0] light;
    logic [7:0] sensor;
    logic [7:0] sum;
  } lin_result_t;

  // Directed table rows: an input item or a register write.
  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_SET_ID,
    ROW_SET_LEN
  } row_op_t;

  typedef struct packed {
    row_op_t    op;
    req_t       req;
    logic [7:0] value;
    logic       typed;     // expected results written into the row
    logic       fill_sum;  // send the correct checksum instead of value
    logic [7:0] pid;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_req_type = REQ_NONE;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_tx_byte;
  logic                 out_last;
  logic [1:0]           out_outcome;
  logic [3:0]           out_rain_level;
  logic [7:0]           out_light_level;
  logic [7:0]           out_sensor_state;
  logic [7:0]           out_expected_sum;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_ID;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Predicted engine state and register copies.
  logic [5:0] cur_frame_id = 6'd0;
  logic [3:0] cur_rsp_len = 4'd8;
  logic       rx_active = 1'b0;
  logic [3:0] rx_count = 4'd0;
  logic [7:0] run_sum = 8'h00;
  logic [7:0] pid_held = 8'h00;
  logic [3:0] rain_held = 4'h0;
  logic [7:0] light_held = 8'h00;
  logic [7:0] status_held = 8'h00;

  lin_result_t results_due[$];
  int unsigned fail_count = 0;
  int unsigned engaged_items = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_armed = 1'b0;

  // Directed stimulus; reset leaves frame id 0 and eight data bytes.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM,    REQ_BYTE,    8'hFF, 1'b1, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_TIMEOUT, 8'h00, 1'b1, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_NONE,    8'h5A, 1'b1, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_START,   8'h00, 1'b1, 1'b0, 8'h80},
    '{ROW_ITEM,    REQ_BYTE,    8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'h80, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'h7F, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'h01, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'h00, 1'b0, 1'b1, 8'h00},
    '{ROW_SET_ID,  REQ_NONE,    8'h3F, 1'b0, 1'b0, 8'h00},
    '{ROW_SET_LEN, REQ_NONE,    8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_START,   8'hFF, 1'b1, 1'b0, 8'hBF},
    '{ROW_ITEM,    REQ_BYTE,    8'h5A, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'hA5, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_NONE,    8'hFF, 1'b1, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_START,   8'h00, 1'b1, 1'b0, 8'hBF},
    '{ROW_ITEM,    REQ_BYTE,    8'hF0, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'h0F, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'hC3, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_START,   8'h00, 1'b1, 1'b0, 8'hBF},
    '{ROW_ITEM,    REQ_BYTE,    8'h12, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_TIMEOUT, 8'h00, 1'b1, 1'b0, 8'h00},
    '{ROW_ITEM,    REQ_BYTE,    8'h77, 1'b1, 1'b0, 8'h00}
  };

  lin_master_frame_poll dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_tx_byte      (out_tx_byte),
    .out_last         (out_last),
    .out_outcome      (out_outcome),
    .out_rain_level   (out_rain_level),
    .out_light_level  (out_light_level),
    .out_sensor_state (out_sensor_state),
    .out_expected_sum (out_expected_sum),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Protected identifier: frame id plus the two LIN 2.x parity bits.
  function automatic logic [7:0] pid_of(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = ^{id[4], id[2], id[1], id[0]};
    p1 = ~(^{id[5], id[4], id[3], id[1]});
    return {p1, p0, id};
  endfunction

  // Enhanced checksum step: 8-bit add, a carry out wraps back in.
  function automatic logic [7:0] sum_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 9'h0FF) s = s - 9'h0FF;
    return s[7:0];
  endfunction

  // Data byte count before the checksum, clamped to the legal range.
  function automatic int unsigned data_bytes();
    int unsigned n;
    n = cur_rsp_len;
    if (n < MIN_DATA_BYTES) n = MIN_DATA_BYTES;
    if (n > MAX_DATA_BYTES) n = MAX_DATA_BYTES;
    return n;
  endfunction

  function automatic lin_result_t mk_result(input kind_t kind, input logic [7:0] tx,
                                            input logic last, input logic [1:0] oc,
                                            input logic [3:0] rain, input logic [7:0] light,
                                            input logic [7:0] sensor, input logic [7:0] sum);
    lin_result_t r;
    r.kind = kind;
    r.tx_byte = tx;
    r.last = last;
    r.outcome = oc;
    r.rain = rain;
    r.light = light;
    r.sensor = sensor;
    r.sum = sum;
    return r;
  endfunction

  // Break, sync and identifier transactions of one header.
  function automatic void push_header(input logic [7:0] pid);
    results_due.push_back(mk_result(KIND_BREAK, 8'h00, 1'b0, OC_OK, 4'h0, 8'h00, 8'h00, 8'h00));
    results_due.push_back(mk_result(KIND_HEADER, SYNC_BYTE, 1'b0, OC_OK, 4'h0, 8'h00, 8'h00,
                                    8'h00));
    results_due.push_back(mk_result(KIND_HEADER, pid, 1'b1, OC_OK, 4'h0, 8'h00, 8'h00, 8'h00));
  endfunction

  function automatic void push_timeout();
    results_due.push_back(mk_result(KIND_OUTCOME, 8'h00, 1'b1, OC_TIMEOUT, 4'h0, 8'h00, 8'h00,
                                    8'h00));
  endfunction

  // Advances the predicted frame engine by one input item; returns 0 when
  // the item is ignored. Results are queued only when record is set.
  function automatic bit frame_engine_step(input req_t req, input logic [7:0] b,
                                           input bit record);
    logic [7:0] csum;
    logic [1:0] oc;
    case (req)
      REQ_START: begin
        pid_held = pid_of(cur_frame_id);
        run_sum = pid_held;
        rx_count = 4'd0;
        rain_held = 4'h0;
        light_held = 8'h00;
        status_held = 8'h00;
        rx_active = 1'b1;
        if (record) push_header(pid_held);
        return 1'b1;
      end
      REQ_TIMEOUT: begin
        if (!rx_active) return 1'b0;
        rx_active = 1'b0;
        rx_count = 4'd0;
        if (record) push_timeout();
        return 1'b1;
      end
      REQ_BYTE: begin
        if (!rx_active) return 1'b0;
        if (rx_count < data_bytes()) begin
          // Data byte: the first three are held, all enter the sum.
          if (rx_count == 4'd0) rain_held = b[3:0];
          else if (rx_count == 4'd1) light_held = b;
          else if (rx_count == 4'd2) status_held = b;
          run_sum = sum_add(run_sum, b);
          rx_count = rx_count + 4'd1;
          return 1'b1;
        end
        // Checksum byte closes the frame.
        csum = ~run_sum;
        oc = (b == csum) ? OC_OK : OC_CSUM_ERR;
        rx_active = 1'b0;
        rx_count = 4'd0;
        if (record) begin
          results_due.push_back(mk_result(KIND_OUTCOME, 8'h00, 1'b1, oc, rain_held,
                                          light_held, status_held, csum));
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string show(input lin_result_t r);
    return {$sformatf("kind=%0d tx=%02h last=%0d oc=%0d ",
                      r.kind, r.tx_byte, r.last, r.outcome),
            $sformatf("rain=%01h light=%02h sensor=%02h sum=%02h",
                      r.rain, r.light, r.sensor, r.sum)};
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("[%0t] %s", $time, msg);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one input transaction after a random gap and waits for acceptance.
  task automatic drive_item(input req_t req, input logic [7:0] b);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random-phase item: drive, predict, and count it if the engine uses it.
  task automatic offer(input req_t req, input logic [7:0] b);
    drive_item(req, b);
    if (frame_engine_step(req, b, 1'b1)) engaged_items++;
  endtask

  // One register write transaction; the predictor copy follows it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_FRAME_ID) cur_frame_id = val[5:0];
    else cur_rsp_len = val[3:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering input, waits for every expected result, then lets
  // bytes still in flight pass through the pipeline.
  task automatic settle();
    int unsigned n;
    @(negedge clk);
    in_valid <= 1'b0;
    n = 0;
    while (results_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived, next %s",
                             results_due.size(), show(results_due[0])));
      results_due.delete();
    end
  endtask

  // Result side: random ready gaps, one long hold when armed, and the check.
  initial begin : result_sink
    lin_result_t got;
    lin_result_t want;
    int unsigned wait_cycles;
    @(posedge rst_n);
    forever begin
      wait_cycles = rx_steady ? 0 : $urandom_range(0, 14);
      if (hold_armed) begin
        wait_cycles = LONG_HOLD;
        hold_armed = 1'b0;
      end
      @(negedge clk);
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.kind = kind_t'(out_kind);
      got.tx_byte = out_tx_byte;
      got.last = out_last;
      got.outcome = out_outcome;
      got.rain = out_rain_level;
      got.light = out_light_level;
      got.sensor = out_sensor_state;
      got.sum = out_expected_sum;
      if (results_due.size() == 0) begin
        note_failure({"unexpected result: ", show(got)});
      end else begin
        want = results_due.pop_front();
        if (got !== want) note_failure({"mismatch: expected ", show(want), " got ", show(got)});
      end
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin : stimulus
    dir_row_t    row;
    logic [7:0]  b;
    bit          took;
    int unsigned phase;
    int unsigned frames;
    int unsigned shape;
    int unsigned nbytes;
    logic [5:0]  len_val;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      case (row.op)
        ROW_SET_ID: begin
          settle();
          write_reg(CFG_FRAME_ID, row.value[5:0]);
        end
        ROW_SET_LEN: begin
          settle();
          write_reg(CFG_RSP_LEN, row.value[5:0]);
        end
        default: begin
          b = row.fill_sum ? ~run_sum : row.value;
          drive_item(row.req, b);
          took = frame_engine_step(row.req, b, !row.typed);
          if (row.typed) begin
            if (row.req == REQ_START) push_header(row.pid);
            else if (row.req == REQ_TIMEOUT && took) push_timeout();
          end
        end
      endcase
    end

    // Random part: each phase picks new settings and idling, then frames.
    phase = 0;
    while (engaged_items < RANDOM_ITEMS) begin
      settle();
      case (phase % 6)
        0: len_val = 6'd0;
        1: len_val = 6'd3;
        2: len_val = 6'd8;
        3: len_val = 6'd15;
        4: len_val = 6'h3F;
        default: len_val = 6'($urandom_range(0, 63));
      endcase
      write_reg(CFG_RSP_LEN, len_val);
      if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_ID, 6'($urandom_range(0, 63)));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // Long receiver hold while input keeps coming back to back.
        hold_armed = 1'b1;
        tx_steady = 1'b1;
      end
      frames = $urandom_range(2, 5);
      repeat (frames) begin
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
          // Noise: any request type, mostly ignored while idle.
          repeat ($urandom_range(1, 3)) offer(req_t'($urandom_range(0, 3)), rand_byte());
        end else if (shape == 1) begin
          // Broken frame: cut short by a timeout, a restart or a stray code.
          offer(REQ_START, rand_byte());
          nbytes = $urandom_range(0, data_bytes());
          repeat (nbytes) offer(REQ_BYTE, rand_byte());
          case ($urandom_range(0, 2))
            0: offer(REQ_TIMEOUT, rand_byte());
            1: offer(REQ_START, rand_byte());
            default: offer(REQ_NONE, rand_byte());
          endcase
        end else begin
          // Well-formed frame, mostly with a correct checksum.
          offer(REQ_START, rand_byte());
          nbytes = data_bytes();
          repeat (nbytes) offer(REQ_BYTE, rand_byte());
          b = ($urandom_range(0, 3) != 0) ? ~run_sum : rand_byte();
          offer(REQ_BYTE, b);
        end
      end
      phase++;
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
design/lmfp_pkg.sv
design/lmfp_core.sv
design/lmfp_out.sv
design/lin_master_frame_poll.sv
tb/tb_top.sv
